// ----- rtl/core/sbpf_pkg.sv -----
// ----------------------------------------------------------------------------
// sbpf_pkg
// Shared types and constants for the servo bus packet framer.
// ----------------------------------------------------------------------------
package sbpf_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] MAX_COUNT = 8'd252;
  localparam logic [7:0] LEN_EXTRA = 8'd3;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PARAM  = 1'b1;

  localparam int QUEUE_DEPTH_DEF = 4;

  // input request
  typedef struct packed {
    logic       kind;
    logic [7:0] dest_id;
    logic [7:0] instr_code;
    logic [7:0] start_address;
    logic [7:0] param_count;
    logic [7:0] param_byte;
  } req_t;

  // wire byte out
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } tx_t;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_PARAM  = 1'b1
  } cmd_op_t;

  // classified command between front and back
  // header: b0=id, b1=len, b2=instr, b3=addr; param: b0=byte
  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       has_cs;
    logic [7:0] cs;
  } cmd_t;

endpackage

// ----- rtl/core/sbpf_front.sv -----
// ----------------------------------------------------------------------------
// sbpf_front
// Accepts requests, tracks the open packet and the running checksum, and
// turns each header or in-packet parameter into a command for the back end.
// ----------------------------------------------------------------------------
module sbpf_front import sbpf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  logic       packet_open;
  logic [7:0] bytes_left;
  logic [7:0] running_sum;

  logic       packet_open_next;
  logic [7:0] bytes_left_next;
  logic [7:0] running_sum_next;

  logic [7:0] cnt;
  logic [7:0] len;
  logic [7:0] left_dec;
  logic       take;

  assign req_ready = cmd_ready;
  assign take      = req_valid && req_ready;

  always_comb begin
    cnt      = (req.param_count > MAX_COUNT) ? MAX_COUNT : req.param_count;
    len      = cnt + LEN_EXTRA;
    left_dec = bytes_left - 8'd1;

    packet_open_next = packet_open;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    cmd_valid        = 1'b0;
    cmd              = '0;

    if (req.kind == KIND_HEADER) begin
      running_sum_next = req.dest_id + len + req.instr_code + req.start_address;
      packet_open_next = (cnt != 8'd0);
      bytes_left_next  = cnt;
      cmd.op           = OP_HEADER;
      cmd.b0           = req.dest_id;
      cmd.b1           = len;
      cmd.b2           = req.instr_code;
      cmd.b3           = req.start_address;
      cmd.has_cs       = (cnt == 8'd0);
      cmd.cs           = ~running_sum_next;
      cmd_valid        = req_valid;
    end else if (packet_open) begin
      running_sum_next = running_sum + req.param_byte;
      bytes_left_next  = left_dec;
      packet_open_next = (left_dec != 8'd0);
      cmd.op           = OP_PARAM;
      cmd.b0           = req.param_byte;
      cmd.has_cs       = (left_dec == 8'd0);
      cmd.cs           = ~running_sum_next;
      cmd_valid        = req_valid;
    end
    // parameter with no open packet: accepted and dropped
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      bytes_left  <= 8'd0;
      running_sum <= 8'd0;
    end else if (take) begin
      packet_open <= packet_open_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

// ----- rtl/core/sbpf_queue.sv -----
// ----------------------------------------------------------------------------
// sbpf_queue
// Small command queue between front and back end.
// ----------------------------------------------------------------------------
module sbpf_queue import sbpf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/sbpf_back.sv -----
// ----------------------------------------------------------------------------
// sbpf_back
// Walks each command byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module sbpf_back import sbpf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic tx_valid,
  input  logic tx_ready,
  output tx_t  tx
);

  localparam logic [2:0] ST_SYNC0 = 3'd0;
  localparam logic [2:0] ST_SYNC1 = 3'd1;
  localparam logic [2:0] ST_ID    = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_INSTR = 3'd4;
  localparam logic [2:0] ST_ADDR  = 3'd5;
  localparam logic [2:0] ST_CSUM  = 3'd6;
  localparam logic [2:0] PS_BYTE  = 3'd0;
  localparam logic [2:0] PS_CSUM  = 3'd1;

  cmd_t       cur;
  logic       cur_valid;
  logic [2:0] step;
  logic [2:0] last_step;
  tx_t        sel;
  logic       adv;
  logic       fin;

  always_comb begin
    sel = '0;
    if (cur.op == OP_HEADER) begin
      last_step = cur.has_cs ? ST_CSUM : ST_ADDR;
      case (step)
        ST_SYNC0: sel.out_byte = SYNC_BYTE;
        ST_SYNC1: sel.out_byte = SYNC_BYTE;
        ST_ID:    sel.out_byte = cur.b0;
        ST_LEN:   sel.out_byte = cur.b1;
        ST_INSTR: sel.out_byte = cur.b2;
        ST_ADDR:  sel.out_byte = cur.b3;
        default:  sel.out_byte = cur.cs;
      endcase
      sel.frame_end = (step == ST_CSUM);
    end else begin
      last_step = cur.has_cs ? PS_CSUM : PS_BYTE;
      sel.out_byte  = (step == PS_BYTE) ? cur.b0 : cur.cs;
      sel.frame_end = (step == PS_CSUM);
    end
  end

  assign adv       = cur_valid && (!tx_valid || tx_ready);
  assign fin       = adv && (step == last_step);
  assign cmd_ready = !cur_valid || fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= 3'd0;
      tx_valid  <= 1'b0;
    end else begin
      if (tx_valid && tx_ready) begin
        tx_valid <= 1'b0;
      end
      if (adv) begin
        tx_valid <= 1'b1;
        step     <= step + 3'd1;
      end
      if (cmd_valid && cmd_ready) begin
        cur_valid <= 1'b1;
        step      <= 3'd0;
      end else if (fin) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx <= sel;
    end
    if (cmd_valid && cmd_ready) begin
      cur <= cmd;
    end
  end

endmodule

// ----- rtl/core/servo_bus_packet_framer_unit.sv -----
// A request passes the queue, the back end's cur register and the tx register.
// Throughput: one request per cycle while the command queue has room; the
// output delivers one byte per cycle unless held by tx_ready, a header
// expands to six or seven bytes. Sustained rate is set by the output stage.
// Reset: synchronous, clears packet state, queue pointers and output valid.
// ----------------------------------------------------------------------------
// servo_bus_packet_framer_unit
// Servo bus instruction packet framer: header and parameter requests in,
// wire bytes with checksum and end-of-frame mark out.
// ----------------------------------------------------------------------------
module servo_bus_packet_framer_unit import sbpf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  // byte channel
  output logic tx_valid,
  input  logic tx_ready,
  output tx_t  tx
);

  // Front end: owns packet_open / bytes_left / running_sum. Each request is
  // classified in its accept cycle: headers and in-packet parameters become
  // one command carrying all their non-sync bytes (checksum precomputed);
  // stray parameters are swallowed.
  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;

  // Queue output to back end
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  sbpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  // Decouples request acceptance from byte emission, so a six byte header
  // does not stall parameter requests behind it until the queue fills.
  sbpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_cmd   (qb_cmd)
  );

  // Back end: steps through the current command into the output register, one
  // byte per cycle unless stalled; next command is loaded as the last byte goes.
  sbpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .tx_valid  (tx_valid),
    .tx_ready  (tx_ready),
    .tx        (tx)
  );

endmodule

// ----- rtl/core/sbpf_checker.sv -----
// ----------------------------------------------------------------------------
// sbpf_checker
// Port-level checks for the servo bus packet framer.
// ----------------------------------------------------------------------------
module sbpf_checker import sbpf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic tx_valid,
  input logic tx_ready,
  input tx_t  tx
);

  // stalled request stays offered with the same payload
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_ready) |=> (req_valid && $stable(req)))
    else $error("request changed while stalled");

  // stalled byte stays offered
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && !tx_ready) |=> tx_valid)
    else $error("tx_valid dropped while stalled");

  a_tx_stable: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && !tx_ready) |=> $stable(tx))
    else $error("tx payload changed while stalled");

  // nothing pending right after reset
  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !tx_valid)
    else $error("tx_valid high after reset");

  // empty queue takes a request right after reset
  a_rst_ready: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> req_ready)
    else $error("req_ready low after reset");

endmodule

bind servo_bus_packet_framer_unit sbpf_checker u_sbpf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .tx_valid  (tx_valid),
  .tx_ready  (tx_ready),
  .tx        (tx)
);

// ----- tb/servo_bus_packet_framer_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_bus_packet_framer_unit_test
// Self-checking bench for the servo bus packet framer. Header and parameter
// requests go in over a valid/ready channel; every accepted request is run
// through a local frame predictor whose bytes are compared, in order, with
// the wire bytes that leave the block. Directed cases come first, then a long
// output hold-off, then random packet streams without and then with random
// idling on both sides.
// ----------------------------------------------------------------------------
module servo_bus_packet_framer_unit_test;
  import sbpf_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles with no handshake on either side
  localparam int HOLD_CYCLES = 80;    // long output hold-off
  localparam int DRAIN_TAIL  = 16;    // quiet cycles after the last byte

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic tx_valid;
  logic tx_ready;
  tx_t  tx;

  servo_bus_packet_framer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .tx_valid  (tx_valid),
    .tx_ready  (tx_ready),
    .tx        (tx)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predictor state: mirrors the framer's packet tracking
  logic       pkt_open;
  logic [7:0] params_left;
  logic [7:0] cks_sum;

  tx_t wire_bytes_due[$];  // bytes still owed by the block, oldest first

  int fail_count      = 0;
  int framed_requests = 0;  // requests that produced bytes
  int stray_dropped   = 0;  // parameter requests with no open packet
  int bytes_checked   = 0;
  int frames_closed   = 0;

  bit req_gaps_on  = 1'b1;
  bit byte_gaps_on = 1'b1;
  int hold_request = 0;     // set at a rising edge, picked up by the ready driver
  int hold_left    = 0;

  // Work out the wire bytes one accepted request causes.
  task automatic frame_predict(input req_t r);
    logic [7:0] cnt;
    logic [7:0] len;
    if (r.kind == KIND_HEADER) begin
      // counts above the limit saturate so the length byte never wraps
      cnt     = (r.param_count > MAX_COUNT) ? MAX_COUNT : r.param_count;
      len     = cnt + LEN_EXTRA;
      cks_sum = r.dest_id + len + r.instr_code + r.start_address;
      wire_bytes_due.push_back(tx_t'{SYNC_BYTE, 1'b0});
      wire_bytes_due.push_back(tx_t'{SYNC_BYTE, 1'b0});
      wire_bytes_due.push_back(tx_t'{r.dest_id, 1'b0});
      wire_bytes_due.push_back(tx_t'{len, 1'b0});
      wire_bytes_due.push_back(tx_t'{r.instr_code, 1'b0});
      wire_bytes_due.push_back(tx_t'{r.start_address, 1'b0});
      if (cnt == 8'd0) begin
        // no parameters: checksum right behind the header
        wire_bytes_due.push_back(tx_t'{~cks_sum, 1'b1});
        pkt_open    = 1'b0;
        params_left = 8'd0;
      end else begin
        // any packet still open is abandoned here
        pkt_open    = 1'b1;
        params_left = cnt;
      end
      framed_requests++;
    end else if (!pkt_open) begin
      stray_dropped++;
    end else begin
      cks_sum = cks_sum + r.param_byte;
      wire_bytes_due.push_back(tx_t'{r.param_byte, 1'b0});
      params_left = params_left - 8'd1;
      if (params_left == 8'd0) begin
        wire_bytes_due.push_back(tx_t'{~cks_sum, 1'b1});
        pkt_open = 1'b0;
      end
      framed_requests++;
    end
  endtask

  function automatic req_t make_header(input logic [7:0] id, input logic [7:0] instr,
                                       input logic [7:0] addr, input logic [7:0] cnt);
    req_t r;
    r.kind          = KIND_HEADER;
    r.dest_id       = id;
    r.instr_code    = instr;
    r.start_address = addr;
    r.param_count   = cnt;
    r.param_byte    = 8'($urandom_range(0, 255));  // ignored on headers
    return r;
  endfunction

  function automatic req_t make_param(input logic [7:0] b);
    req_t r;
    r.kind          = KIND_PARAM;
    r.dest_id       = 8'($urandom_range(0, 255));  // header fields ignored here
    r.instr_code    = 8'($urandom_range(0, 255));
    r.start_address = 8'($urandom_range(0, 255));
    r.param_count   = 8'($urandom_range(0, 255));
    r.param_byte    = b;
    return r;
  endfunction

  // Offer one request; called and returns at a falling edge.
  task automatic send_request(input req_t r);
    while (req_gaps_on && $urandom_range(0, 99) < 27) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    frame_predict(r);
    @(negedge clk);
  endtask

  // Sender stops until every owed byte has come out.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (wire_bytes_due.size() != 0) @(negedge clk);
  endtask

  // the last request is already taken, so nothing stays offered meanwhile
  task automatic set_idling(input bit req_on, input bit byte_on);
    req_valid <= 1'b0;
    @(posedge clk);
    req_gaps_on  = req_on;
    byte_gaps_on = byte_on;
    @(negedge clk);
  endtask

  // ready driver for the byte side, with the long hold-off
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      tx_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (byte_gaps_on) begin
      tx_ready <= ($urandom_range(0, 99) >= 27);
    end else begin
      tx_ready <= 1'b1;
    end
  end

  // byte checker: each accepted byte against the oldest owed one
  always @(posedge clk) begin : check_bytes
    tx_t want;
    if (!rst && tx_valid && tx_ready) begin
      if (wire_bytes_due.size() == 0) begin
        $error("unexpected byte: out_byte %02h frame_end %0b", tx.out_byte, tx.frame_end);
        fail_count++;
      end else begin
        want = wire_bytes_due.pop_front();
        if (tx.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, tx.out_byte);
          fail_count++;
        end
        if (tx.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, actual %0b", want.frame_end, tx.frame_end);
          fail_count++;
        end
        bytes_checked++;
        if (want.frame_end) frames_closed++;
      end
    end
  end

  // watchdog: too long with no handshake on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (tx_valid && tx_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: %0d bytes still owed", wire_bytes_due.size());
        $display("servo_bus_packet_framer_unit_test: errors");
        $finish;
      end
    end
  end

  // parameters with no packet open are dropped, right out of reset
  task automatic test_stray_params();
    send_request(make_param(8'h00));
    send_request(make_param(8'hFF));
  endtask

  // field extremes, broadcast id, id 255, zero count, read and sync write
  task automatic test_header_extremes();
    send_request(make_header(8'h00, 8'h00, 8'h00, 8'd0));
    send_request(make_header(8'hFF, 8'hFF, 8'hFF, 8'd0));
    send_request(make_header(8'hFE, 8'h83, 8'h1E, 8'd1));
    send_request(make_param(8'hFF));
    send_request(make_header(8'h01, 8'h03, 8'h24, 8'd2));
    send_request(make_param(8'h00));
    send_request(make_param(8'h80));
    send_request(make_header(8'h55, 8'h02, 8'h2B, 8'd1));
    send_request(make_param(8'h02));
  endtask

  // counts at and past the limit; large packets left open and abandoned
  task automatic test_count_saturation();
    send_request(make_header(8'h10, 8'h03, 8'h1E, 8'd253));
    send_request(make_param(8'h01));
    send_request(make_param(8'hFE));
    send_request(make_param(8'h7F));
    send_request(make_header(8'h11, 8'h03, 8'h20, 8'd255));
    send_request(make_param(8'h10));
    send_request(make_header(8'h12, 8'h83, 8'h1E, 8'd252));
    send_request(make_header(8'h13, 8'h03, 8'h19, 8'd1));
    send_request(make_param(8'hAA));
  endtask

  // header mid-packet, then a zero-count close and a stray parameter
  task automatic test_header_abandons();
    send_request(make_header(8'h07, 8'h03, 8'h1E, 8'd3));
    send_request(make_param(8'h5A));
    send_request(make_header(8'h08, 8'h01, 8'h00, 8'd0));
    send_request(make_param(8'hC3));
  endtask

  // output held off while requests keep coming, so the input side stalls
  task automatic test_backpressure();
    set_idling(1'b0, 1'b0);
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    @(negedge clk);
    send_request(make_header(8'h21, 8'h03, 8'h1E, 8'd12));
    repeat (12) send_request(make_param(8'($urandom_range(0, 255))));
    send_request(make_header(8'h22, 8'h01, 8'h00, 8'd0));
    send_request(make_header(8'hFE, 8'h06, 8'h00, 8'd0));
    wait_drained();
    set_idling(1'b1, 1'b1);
  endtask

  // random packet streams: mostly complete frames, some abandoned, some strays
  task automatic test_random_packets(input int target);
    int start;
    int pick;
    int cnt;
    int n_params;
    start = framed_requests;
    while (framed_requests - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_request(make_param(8'($urandom_range(0, 255))));
      end else begin
        if (pick < 14) begin
          // large or saturating count, cut short by the next header
          cnt      = $urandom_range(7, 255);
          n_params = $urandom_range(0, 4);
        end else if (pick < 24) begin
          cnt      = $urandom_range(1, 6);
          n_params = $urandom_range(0, cnt - 1);
        end else begin
          cnt      = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
          n_params = cnt;
        end
        send_request(make_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'(cnt)));
        repeat (n_params) send_request(make_param(8'($urandom_range(0, 255))));
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    tx_ready    = 1'b0;
    pkt_open    = 1'b0;
    params_left = 8'd0;
    cks_sum     = 8'd0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_stray_params();
    test_header_extremes();
    test_count_saturation();
    test_header_abandons();
    wait_drained();

    test_backpressure();

    // a stretch with no idling on either side, then random idling
    set_idling(1'b0, 1'b0);
    test_random_packets(25);
    set_idling(1'b1, 1'b1);
    test_random_packets(55);

    wait_drained();
    repeat (DRAIN_TAIL) @(negedge clk);

    $display("covered: %0d framing requests, %0d stray parameters dropped",
             framed_requests, stray_dropped);
    $display("covered: %0d wire bytes checked, %0d frames closed by checksum",
             bytes_checked, frames_closed);
    if (fail_count == 0) begin
      $display("servo_bus_packet_framer_unit_test: clean");
    end else begin
      $display("servo_bus_packet_framer_unit_test: errors");
    end
    $finish;
  end

endmodule
